FILE: sv/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, constants and helper functions of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int NUM_PAGES = 1024;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int MAX_ORDER = 15;
  localparam int ORD_W     = 4;
  localparam int CODE_W    = 5;
  localparam int STAMP_W   = 32;
  localparam int REQ_W     = 16;
  localparam int SIZE_W    = 17;
  localparam int PT_W      = 7;

  // page table entry bits: recorded order+1 in the low bits, free head, allocated
  localparam int PT_FREE_BIT = 5;
  localparam int PT_RESV_BIT = 6;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_INVALID = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CARVE,
    ST_FIND,
    ST_ALLOC_WR,
    ST_FREE_CHK,
    ST_FREE_WR
  } state_t;

  // one ring cell: page table entry and insertion stamp
  typedef struct packed {
    logic [PT_W-1:0]    pt;
    logic [STAMP_W-1:0] stamp;
  } ent_t;

  // index of the highest set bit
  function automatic logic [CODE_W-1:0] f_flog2(input logic [SIZE_W-1:0] v);
    logic [CODE_W-1:0] r;
    r = '0;
    for (int k = 0; k < SIZE_W; k++) begin
      if (v[k]) r = CODE_W'(k);
    end
    return r;
  endfunction

  // trailing zeros of a page index, zero aligns to the top order
  function automatic logic [ORD_W-1:0] f_ctz(input logic [IDX_W-1:0] v);
    logic [ORD_W-1:0] r;
    r = ORD_W'(MAX_ORDER);
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if (v[k]) r = ORD_W'(k);
    end
    return r;
  endfunction

  // smallest order whose block covers n pages, capped at the top order
  function automatic logic [ORD_W-1:0] f_clog2_req(input logic [REQ_W-1:0] n);
    logic [ORD_W-1:0] r;
    r = '0;
    for (int k = 0; k < MAX_ORDER; k++) begin
      if ((SIZE_W'(1) << k) < {1'b0, n}) r = ORD_W'(k + 1);
    end
    return r;
  endfunction

  // entry is a free head of the given order
  function automatic logic f_listed(input logic [PT_W-1:0] pt, input logic [ORD_W-1:0] ord);
    return pt[PT_FREE_BIT] && (pt[CODE_W-1:0] == (CODE_W'(ord) + CODE_W'(1)));
  endfunction

  // buddy of the order-k block that holds idx
  function automatic logic [IDX_W-1:0] f_buddy(input logic [IDX_W-1:0] idx, input int k);
    logic [IDX_W-1:0] bit_k;
    bit_k = IDX_W'(1) << k;
    return (idx & ~(bit_k - IDX_W'(1))) ^ bit_k;
  endfunction

endpackage

FILE: sv/bpa_cell.sv
// ----------------------------------------------------------------------------
// bpa_cell
// One ring cell: holds a page entry and passes it to its neighbor each clock.
// ----------------------------------------------------------------------------
module bpa_cell import bpa_pkg::*; (
  input  logic clk,
  input  ent_t d,
  output ent_t q
);

  // entry moves one place along the ring every cycle
  always_ff @(posedge clk) begin
    q <= d;
  end

endmodule

FILE: sv/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer at the head of the ring: reads and rewrites one page per clock,
// runs carve, search, split, check and merge passes.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [REQ_W-1:0]   in_request_pages,
  input  logic [IDX_W-1:0]   in_block_index,
  input  logic               cfg_wr_en,
  input  logic [CNT_W-1:0]   cfg_wr_data,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [IDX_W-1:0]   out_granted_index,
  output logic [CNT_W-1:0]   out_free_pages,
  input  ent_t               hd,
  output ent_t               tail
);

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     pos_r;
  logic                 run_r, run_nxt;
  logic [CNT_W-1:0]     pc_r, pc_nxt;
  logic [CNT_W-1:0]     free_r, free_nxt;
  logic [STAMP_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     cnext_r, cnext_nxt;
  logic [ORD_W-1:0]     need_r, need_nxt;
  logic [ORD_W-1:0]     got_r, got_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [STAMP_W-1:0]   best_stamp_r, best_stamp_nxt;
  logic [REQ_W-1:0]     req_r, req_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [ORD_W-1:0]     ord_r, ord_nxt;
  logic                 bad_r, bad_nxt;
  logic [SIZE_W-1:0]    end_r, end_nxt;
  logic [MAX_ORDER:0]   lst_r, lst_nxt;
  logic                 out_valid_r, out_valid_nxt;
  stat_t                out_status_r, out_status_nxt;
  logic [IDX_W-1:0]     out_gi_r, out_gi_nxt;
  logic [CNT_W-1:0]     out_fp_r, out_fp_nxt;

  logic                 act, last_c, cfg_ok, acc, imm_inv, imm_nsp;
  logic [CNT_W-1:0]     pos_ext;
  logic [SIZE_W-1:0]    pos17;
  logic                 found_eff, find_hit, found_any;
  logic                 at_idx;
  logic [CODE_W-1:0]    h_code, h_ord;
  logic [SIZE_W-1:0]    h_size, h_end;
  logic                 h_bad, chk_bad_cur;
  logic [MAX_ORDER:0]   lst_cur;
  logic [ORD_W-1:0]     m_ord;
  logic                 m_stop;
  logic [SIZE_W-1:0]    low_mask, fsize;
  logic [IDX_W-1:0]     fin;
  logic                 is_bud, in_rng;
  logic [IDX_W-1:0]     d_off;
  logic [CODE_W-1:0]    dk;
  logic [CNT_W-1:0]     nsize;
  logic                 in_blk, split;
  logic                 c_hit;
  logic [CNT_W-1:0]     rem, c_size;
  logic [CODE_W-1:0]    rem_lg;
  logic [ORD_W-1:0]     c_align, c_ord;

  // pass timing: every pass sweeps indices 0 up to the last cell
  assign pos_ext = {1'b0, pos_r};
  assign pos17   = SIZE_W'(pos_r);
  assign act     = (pos_r == '0) || run_r;
  assign last_c  = act && (pos_r == '1);
  assign busy    = (state_r != ST_IDLE);

  // request decode
  assign cfg_ok  = cfg_wr_en && (cfg_wr_data != '0) && (cfg_wr_data <= CNT_W'(NUM_PAGES));
  assign acc     = start && !busy;
  assign imm_inv = (in_request_pages == '0) ||
                   ((in_kind == KIND_FREE) && ({1'b0, in_block_index} >= pc_r));
  assign imm_nsp = (in_kind == KIND_ALLOC) && (in_request_pages > REQ_W'(free_r));

  // carve: maximal aligned block at the next head
  always_comb begin
    c_hit   = act && (pos_ext == cnext_r) && (pos_ext < pc_r);
    rem     = pc_r - pos_ext;
    rem_lg  = f_flog2(SIZE_W'(rem));
    c_align = f_ctz(pos_r);
    c_ord   = (CODE_W'(c_align) < rem_lg) ? c_align : rem_lg[ORD_W-1:0];
    c_size  = CNT_W'(1) << c_ord;
  end

  // search: most recent free head of order got
  always_comb begin
    found_eff = run_r && found_r;
    find_hit  = act && (pos_ext < pc_r) && f_listed(hd.pt, got_r) &&
                (!found_eff || (hd.stamp > best_stamp_r));
    found_any = found_eff || find_hit;
  end

  // free check: head decode, allocated pages in range, buddy gather
  always_comb begin
    at_idx = act && (pos_r == idx_r);
    h_code = hd.pt[CODE_W-1:0];
    h_bad  = 1'b0;
    if (h_code != '0) begin
      h_ord = h_code - CODE_W'(1);
      if (h_ord > CODE_W'(MAX_ORDER)) h_bad = 1'b1;
    end else begin
      h_ord = f_flog2(SIZE_W'(req_r));
      if ((req_r & (req_r - REQ_W'(1))) != '0) h_bad = 1'b1;
    end
    h_size = SIZE_W'(1) << h_ord[ORD_W-1:0];
    h_end  = SIZE_W'(idx_r) + h_size;
    if (h_end > SIZE_W'(pc_r)) h_bad = 1'b1;
    if ((idx_r & (h_size[IDX_W-1:0] - IDX_W'(1))) != '0) h_bad = 1'b1;
    if (!hd.pt[PT_RESV_BIT]) h_bad = 1'b1;
    chk_bad_cur = 1'b0;
    if (at_idx) begin
      chk_bad_cur = h_bad;
    end else if (act && (pos_r > idx_r) && (pos17 < end_r) && !hd.pt[PT_RESV_BIT]) begin
      chk_bad_cur = 1'b1;
    end
    lst_cur = '0;
    for (int k = 0; k < IDX_W; k++) begin
      if (act && (pos_r == f_buddy(idx_r, k)) && ({1'b0, f_buddy(idx_r, k)} < pc_r) &&
          f_listed(hd.pt, ORD_W'(k))) begin
        lst_cur[k] = 1'b1;
      end
    end
  end

  // merge: final order, head and buddies to clear
  always_comb begin
    m_ord  = ord_r;
    m_stop = 1'b0;
    for (int k = 0; k <= MAX_ORDER; k++) begin
      if ((ORD_W'(k) >= ord_r) && !m_stop) begin
        if ((k < MAX_ORDER) && lst_r[k]) m_ord = ORD_W'(k + 1);
        else m_stop = 1'b1;
      end
    end
    low_mask = (SIZE_W'(1) << m_ord) - SIZE_W'(1);
    fin      = idx_r & ~low_mask[IDX_W-1:0];
    fsize    = SIZE_W'(1) << ord_r;
    in_rng   = (pos_r >= idx_r) && (pos17 < end_r);
    is_bud   = 1'b0;
    for (int k = 0; k < IDX_W; k++) begin
      if ((ORD_W'(k) >= ord_r) && (ORD_W'(k) < m_ord) && (pos_r == f_buddy(idx_r, k))) begin
        is_bud = 1'b1;
      end
    end
  end

  // split: granted range and right halves handed to lower orders
  always_comb begin
    d_off  = pos_r - best_idx_r;
    dk     = f_flog2(SIZE_W'(d_off));
    nsize  = CNT_W'(1) << need_r;
    in_blk = (pos_r >= best_idx_r) && ({1'b0, d_off} < nsize);
    split  = (pos_r > best_idx_r) && ((d_off & (d_off - IDX_W'(1))) == '0) &&
             (dk >= CODE_W'(need_r)) && (dk < CODE_W'(got_r));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cfg_ok) state_nxt = ST_CARVE;
        else if (acc && !imm_inv && !imm_nsp)
          state_nxt = (in_kind == KIND_ALLOC) ? ST_FIND : ST_FREE_CHK;
      end
      ST_CARVE: begin
        if (last_c) state_nxt = ST_IDLE;
      end
      ST_FIND: begin
        if (last_c) begin
          if (found_any) state_nxt = ST_ALLOC_WR;
          else if (got_r == ORD_W'(MAX_ORDER)) state_nxt = ST_IDLE;
        end
      end
      ST_ALLOC_WR: begin
        if (last_c) state_nxt = ST_IDLE;
      end
      ST_FREE_CHK: begin
        if (last_c) state_nxt = (bad_r || chk_bad_cur) ? ST_IDLE : ST_FREE_WR;
      end
      ST_FREE_WR: begin
        if (last_c) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    tail           = hd;
    run_nxt        = 1'b0;
    pc_nxt         = pc_r;
    free_nxt       = free_r;
    cnt_nxt        = cnt_r;
    cnext_nxt      = cnext_r;
    need_nxt       = need_r;
    got_nxt        = got_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_stamp_nxt = best_stamp_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    ord_nxt        = ord_r;
    bad_nxt        = bad_r;
    end_nxt        = end_r;
    lst_nxt        = lst_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_gi_nxt     = out_gi_r;
    out_fp_nxt     = out_fp_r;
    case (state_r)
      ST_IDLE: begin
        if (cfg_ok) begin
          pc_nxt    = cfg_wr_data;
          free_nxt  = '0;
          cnt_nxt   = '0;
          cnext_nxt = '0;
        end else if (acc) begin
          req_nxt   = in_request_pages;
          idx_nxt   = in_block_index;
          need_nxt  = f_clog2_req(in_request_pages);
          got_nxt   = f_clog2_req(in_request_pages);
          found_nxt = 1'b0;
          bad_nxt   = 1'b0;
          lst_nxt   = '0;
          end_nxt   = '0;
          if (imm_inv || imm_nsp) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = imm_inv ? STAT_INVALID : STAT_NOSPACE;
            out_gi_nxt     = '0;
            out_fp_nxt     = free_r;
          end
        end
      end
      ST_CARVE: begin
        run_nxt = act && !last_c;
        if (act) begin
          tail = '0;
          if (c_hit) begin
            tail.pt    = PT_W'({1'b0, 1'b1, CODE_W'(c_ord) + CODE_W'(1)});
            tail.stamp = cnt_r;
            cnt_nxt    = cnt_r + STAMP_W'(1);
            free_nxt   = free_r + c_size;
            cnext_nxt  = pos_ext + c_size;
          end
        end
      end
      ST_FIND: begin
        run_nxt   = act && !last_c;
        found_nxt = found_any;
        if (find_hit) begin
          best_idx_nxt   = pos_r;
          best_stamp_nxt = hd.stamp;
        end
        if (last_c && !found_any) begin
          if (got_r == ORD_W'(MAX_ORDER)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_NOSPACE;
            out_gi_nxt     = '0;
            out_fp_nxt     = free_r;
          end else begin
            got_nxt = got_r + ORD_W'(1);
          end
        end
      end
      ST_ALLOC_WR: begin
        run_nxt = act && !last_c;
        if (act) begin
          if (pos_r == best_idx_r) begin
            tail.pt = PT_W'({1'b1, 1'b0, CODE_W'(need_r) + CODE_W'(1)});
          end else if (in_blk) begin
            tail.pt = PT_W'({1'b1, 1'b0, hd.pt[CODE_W-1:0]});
          end else if (split) begin
            tail.pt    = PT_W'({hd.pt[PT_RESV_BIT], 1'b1, dk + CODE_W'(1)});
            tail.stamp = cnt_r + STAMP_W'(got_r) - STAMP_W'(1) - STAMP_W'(dk);
          end
        end
        if (last_c) begin
          cnt_nxt        = cnt_r + STAMP_W'(got_r - need_r);
          free_nxt       = (free_r >= nsize) ? (free_r - nsize) : '0;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_gi_nxt     = best_idx_r;
          out_fp_nxt     = (free_r >= nsize) ? (free_r - nsize) : '0;
        end
      end
      ST_FREE_CHK: begin
        run_nxt = act && !last_c;
        bad_nxt = bad_r || chk_bad_cur;
        lst_nxt = lst_r | lst_cur;
        if (at_idx) begin
          ord_nxt = h_ord[ORD_W-1:0];
          end_nxt = h_end;
        end
        if (last_c && (bad_r || chk_bad_cur)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_INVALID;
          out_gi_nxt     = '0;
          out_fp_nxt     = free_r;
        end
      end
      ST_FREE_WR: begin
        run_nxt = act && !last_c;
        if (act) begin
          if (pos_r == fin) begin
            tail.pt    = (fin == idx_r) ?
                         PT_W'({1'b0, 1'b1, CODE_W'(m_ord) + CODE_W'(1)}) :
                         PT_W'({hd.pt[PT_RESV_BIT], 1'b1, CODE_W'(m_ord) + CODE_W'(1)});
            tail.stamp = cnt_r;
          end else if (pos_r == idx_r) begin
            tail.pt = '0;
          end else if (in_rng) begin
            tail.pt = PT_W'({2'b00, hd.pt[CODE_W-1:0]});
          end else if (is_bud) begin
            tail.pt = PT_W'({hd.pt[PT_RESV_BIT], 6'b0});
          end
        end
        if (last_c) begin
          cnt_nxt        = cnt_r + STAMP_W'(1);
          free_nxt       = free_r + fsize[CNT_W-1:0];
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_gi_nxt     = '0;
          out_fp_nxt     = free_r + fsize[CNT_W-1:0];
        end
      end
      default: begin
        run_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CARVE;
      pos_r       <= '0;
      run_r       <= 1'b0;
      pc_r        <= CNT_W'(NUM_PAGES);
      free_r      <= '0;
      cnt_r       <= '0;
      cnext_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_r + IDX_W'(1);
      run_r       <= run_nxt;
      pc_r        <= pc_nxt;
      free_r      <= free_nxt;
      cnt_r       <= cnt_nxt;
      cnext_r     <= cnext_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers of the current request
  always_ff @(posedge clk) begin
    need_r       <= need_nxt;
    got_r        <= got_nxt;
    found_r      <= found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_stamp_r <= best_stamp_nxt;
    req_r        <= req_nxt;
    idx_r        <= idx_nxt;
    ord_r        <= ord_nxt;
    bad_r        <= bad_nxt;
    end_r        <= end_nxt;
    lst_r        <= lst_nxt;
    out_status_r <= out_status_nxt;
    out_gi_r     <= out_gi_nxt;
    out_fp_r     <= out_fp_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_gi_r;
  assign out_free_pages    = out_fp_r;

endmodule

FILE: sv/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over a 1024-page pool kept in a rotating ring of cells.
// ----------------------------------------------------------------------------
// The page entries circulate through a ring of 1024 cells, one entry passing
// the controller each clock, so every pass over the pool starts when page 0
// comes round. A rejected request (zero pages, allocate above the free total,
// free of an index outside the pool) answers in the following cycle, with busy
// staying low. An allocate takes one search pass per order tried from the
// rounded request upward plus, when a block is found, one split pass; a free
// takes a check pass and, unless the check fails, a merge pass. After reset
// and after each valid page count write (1 to 1024) the pool is recarved in
// one pass, during which busy is high. A result sits on the out_ ports for a
// single cycle marked by out_valid; the receiver must take it then.
// ----------------------------------------------------------------------------
module buddy_page_allocator import bpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [REQ_W-1:0]   in_request_pages,
  input  logic [IDX_W-1:0]   in_block_index,
  input  logic               cfg_wr_en,
  input  logic [CNT_W-1:0]   cfg_wr_data,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [IDX_W-1:0]   out_granted_index,
  output logic [CNT_W-1:0]   out_free_pages
);

  ent_t ring_q [NUM_PAGES];
  ent_t tail;

  // sequencer at the ring head
  bpa_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_request_pages  (in_request_pages),
    .in_block_index    (in_block_index),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_free_pages    (out_free_pages),
    .hd                (ring_q[0]),
    .tail              (tail)
  );

  // ring of page cells, the rewritten head entry re-enters at the tail
  for (genvar g = 0; g < NUM_PAGES; g++) begin : g_ring
    if (g == NUM_PAGES - 1) begin : g_tail
      bpa_cell u_cell (.clk(clk), .d(tail), .q(ring_q[g]));
    end else begin : g_body
      bpa_cell u_cell (.clk(clk), .d(ring_q[g+1]), .q(ring_q[g]));
    end
  end

  // a result beat only comes while idle
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // only a granted allocate carries an index
  a_gi_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |-> (out_granted_index == '0))
    else $error("granted index on failed request");

  // an accepted request either answers at once or starts work
  a_acc_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted request dropped");

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the buddy page allocator: a directed table followed
// by random allocate/free traffic over several page counts, each result beat
// checked against its typed row or a cycle-free page table model in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import bpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 60000;
  localparam int NUM_PHASES  = 9;

  typedef struct {
    stat_t            status;
    logic [IDX_W-1:0] granted;
    logic [CNT_W-1:0] free_pages;
  } grant_t;

  typedef struct {
    logic             kind;
    logic [REQ_W-1:0] pages;
    logic [IDX_W-1:0] index;
    bit               typed;
    stat_t            status;
    logic [IDX_W-1:0] granted;
    logic [CNT_W-1:0] free_pages;
  } row_t;

  typedef struct {
    int unsigned head;
    int unsigned ord;
  } live_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_kind = KIND_ALLOC;
  logic [REQ_W-1:0]   in_request_pages = '0;
  logic [IDX_W-1:0]   in_block_index = '0;
  logic               cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]   cfg_wr_data = '0;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [IDX_W-1:0]   out_granted_index;
  logic [CNT_W-1:0]   out_free_pages;

  buddy_page_allocator u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_request_pages  (in_request_pages),
    .in_block_index    (in_block_index),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_free_pages    (out_free_pages)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the allocator state
  logic [PT_W-1:0] pg_tab [NUM_PAGES];
  int unsigned     pg_stamp [NUM_PAGES];
  int unsigned     stamp_ctr;
  int unsigned     free_total;
  int unsigned     pool_pages;

  grant_t      pending_grants [$];
  live_t       live_blocks [$];
  int          fail_count = 0;
  int          stall_cycles = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic bit pool_listed(int unsigned idx, int unsigned ord);
    return pg_tab[idx][PT_FREE_BIT] && (pg_tab[idx][CODE_W-1:0] == ord + 1);
  endfunction

  function automatic void pool_insert(int unsigned idx, int unsigned ord);
    pg_tab[idx] = (pg_tab[idx] & (1 << PT_RESV_BIT)) | (1 << PT_FREE_BIT) | (ord + 1);
    pg_stamp[idx] = stamp_ctr;
    stamp_ctr++;
  endfunction

  function automatic bit pool_newest(int unsigned ord, output int unsigned where);
    bit found;
    found = 0;
    where = 0;
    for (int unsigned i = 0; i < pool_pages; i++) begin
      if (pool_listed(i, ord) && (!found || pg_stamp[i] > pg_stamp[where])) begin
        where = i;
        found = 1;
      end
    end
    return found;
  endfunction

  function automatic void pool_carve();
    int unsigned offset, rem, size, ord;
    offset = 0;
    rem = pool_pages;
    foreach (pg_tab[i]) begin
      pg_tab[i] = '0;
      pg_stamp[i] = 0;
    end
    stamp_ctr = 0;
    free_total = 0;
    live_blocks.delete();
    while (rem > 0) begin
      size = 1;
      ord = 0;
      while (ord + 1 <= MAX_ORDER && (size << 1) <= rem && (offset % (size << 1)) == 0) begin
        size <<= 1;
        ord++;
      end
      pool_insert(offset, ord);
      free_total += size;
      offset += size;
      rem -= size;
    end
  endfunction

  function automatic void pool_config(int unsigned value);
    if (value >= 1 && value <= NUM_PAGES) begin
      pool_pages = value;
      pool_carve();
    end
  endfunction

  function automatic stat_t pool_alloc(int unsigned n, output int unsigned blk);
    int unsigned need, got, size;
    blk = 0;
    need = 0;
    if (n == 0) return STAT_INVALID;
    if (n > free_total) return STAT_NOSPACE;
    while ((1 << need) < n && need < MAX_ORDER) need++;
    got = need;
    while (got <= MAX_ORDER && !pool_newest(got, blk)) got++;
    if (got > MAX_ORDER) return STAT_NOSPACE;
    pg_tab[blk][PT_FREE_BIT] = 1'b0;
    size = 1 << got;
    // split off right halves
    while (got > need) begin
      got--;
      size >>= 1;
      if (blk + size < NUM_PAGES) pool_insert(blk + size, got);
    end
    size = 1 << need;
    free_total = (free_total >= size) ? free_total - size : 0;
    pg_tab[blk][CODE_W-1:0] = need + 1;
    for (int unsigned i = 0; i < size && blk + i < NUM_PAGES; i++) begin
      pg_tab[blk + i][PT_FREE_BIT] = 1'b0;
      pg_tab[blk + i][PT_RESV_BIT] = 1'b1;
    end
    live_blocks.push_back('{head: blk, ord: need});
    return STAT_OK;
  endfunction

  function automatic stat_t pool_free(int unsigned n, int unsigned idx);
    int unsigned code, ord, size, buddy;
    if (n == 0 || idx >= pool_pages) return STAT_INVALID;
    code = pg_tab[idx][CODE_W-1:0];
    if (code != 0) begin
      ord = code - 1;
      if (ord > MAX_ORDER) return STAT_INVALID;
      size = 1 << ord;
    end else begin
      if ((n & (n - 1)) != 0) return STAT_INVALID;
      size = n;
      ord = 0;
      while ((1 << ord) < size) ord++;
      if (ord > MAX_ORDER) return STAT_INVALID;
    end
    if (idx + size > pool_pages || (idx % size) != 0) return STAT_INVALID;
    for (int unsigned i = 0; i < size; i++)
      if (!pg_tab[idx + i][PT_RESV_BIT]) return STAT_INVALID;
    for (int unsigned i = 0; i < size; i++) pg_tab[idx + i] &= 7'h1F;
    pg_tab[idx] = '0;
    free_total += size;
    for (int i = live_blocks.size() - 1; i >= 0; i--)
      if (live_blocks[i].head >= idx && live_blocks[i].head < idx + size) live_blocks.delete(i);
    // merge with free buddies of equal order
    while (ord < MAX_ORDER) begin
      buddy = idx ^ (1 << ord);
      if (buddy >= pool_pages || !pool_listed(buddy, ord)) break;
      pg_tab[buddy] &= 7'h40;
      if (buddy < idx) begin
        pg_tab[idx] &= 7'h40;
        idx = buddy;
      end
      ord++;
    end
    pool_insert(idx, ord);
    return STAT_OK;
  endfunction

  // expected beat for one accepted request
  function automatic grant_t predict_grant(logic kind, int unsigned pages, int unsigned index);
    grant_t g;
    int unsigned blk;
    blk = 0;
    if (kind == KIND_ALLOC) g.status = pool_alloc(pages, blk);
    else g.status = pool_free(pages, index);
    g.granted = (g.status == STAT_OK && kind == KIND_ALLOC) ? IDX_W'(blk) : '0;
    g.free_pages = CNT_W'(free_total);
    return g;
  endfunction

  // drive one request and wait for it to be taken
  task automatic send_request(input row_t r, input bit allow_gap);
    grant_t g;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= r.kind;
    in_request_pages <= r.pages;
    in_block_index <= r.index;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    g = predict_grant(r.kind, r.pages, r.index);
    if (r.typed) begin
      g.status = r.status;
      g.granted = r.granted;
      g.free_pages = r.free_pages;
    end
    pending_grants.push_back(g);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_page_count(input int unsigned value);
    drain_results();
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= CNT_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pool_config(value & 11'h7FF);
    repeat (4) @(posedge clk);
  endtask

  function automatic row_t random_row();
    row_t r;
    int unsigned pick, lb;
    r.typed = 0;
    r.status = STAT_OK;
    r.granted = '0;
    r.free_pages = '0;
    r.index = IDX_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // allocation of a mostly small size
      r.kind = KIND_ALLOC;
      if ($urandom_range(0, 9) == 0) r.pages = REQ_W'($urandom_range(1, 1024));
      else r.pages = REQ_W'($urandom_range(1, 12));
    end else if (pick < 85 && live_blocks.size() != 0) begin
      // well-formed free of a live block
      lb = $urandom_range(0, live_blocks.size() - 1);
      r.kind = KIND_FREE;
      r.index = IDX_W'(live_blocks[lb].head);
      r.pages = REQ_W'(1 << live_blocks[lb].ord);
    end else begin
      r.kind = logic'($urandom_range(0, 1));
      r.pages = (pick % 2) ? REQ_W'($urandom) : REQ_W'($urandom_range(0, 4));
    end
    return r;
  endfunction

  // result beats against the oldest expectation
  always @(negedge clk) begin
    grant_t want;
    if (rst_n && out_valid) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("unexpected beat, status", out_status, 0);
      end else begin
        want = pending_grants.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_granted_index !== want.granted)
          report_mismatch("granted_index", out_granted_index, want.granted);
        if (out_free_pages !== want.free_pages)
          report_mismatch("free_pages", out_free_pages, want.free_pages);
      end
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_wr_en) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    row_t        dir_rows [$];
    int unsigned phase_cfg [NUM_PHASES];
    pool_pages = NUM_PAGES;
    pool_carve();
    phase_cfg = '{1024, 1, 0, 1000, 2047, 7, 513, 1024, 0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: typed where obvious, predicted otherwise
    dir_rows = '{
      '{KIND_ALLOC, 16'd0,     10'd0,    1, STAT_INVALID, 10'd0, 11'd1024},
      '{KIND_ALLOC, 16'd2000,  10'd0,    1, STAT_NOSPACE, 10'd0, 11'd1024},
      '{KIND_ALLOC, 16'hFFFF,  10'h3FF,  1, STAT_NOSPACE, 10'd0, 11'd1024},
      '{KIND_FREE,  16'd0,     10'd0,    1, STAT_INVALID, 10'd0, 11'd1024},
      '{KIND_FREE,  16'd1,     10'd0,    1, STAT_INVALID, 10'd0, 11'd1024},
      '{KIND_ALLOC, 16'd1,     10'h3FF,  1, STAT_OK,      10'd0, 11'd1023},
      '{KIND_ALLOC, 16'd3,     10'd0,    0, STAT_OK,      10'd0, 11'd0},
      '{KIND_ALLOC, 16'd1000,  10'd0,    0, STAT_OK,      10'd0, 11'd0},
      '{KIND_FREE,  16'd1,     10'd1,    0, STAT_OK,      10'd0, 11'd0},
      '{KIND_FREE,  16'd1,     10'd0,    0, STAT_OK,      10'd0, 11'd0},
      '{KIND_FREE,  16'd4,     10'd4,    0, STAT_OK,      10'd0, 11'd0},
      '{KIND_ALLOC, 16'd512,   10'd0,    0, STAT_OK,      10'd0, 11'd0},
      '{KIND_ALLOC, 16'd512,   10'd0,    0, STAT_OK,      10'd0, 11'd0},
      '{KIND_ALLOC, 16'd1,     10'd0,    0, STAT_OK,      10'd0, 11'd0},
      '{KIND_FREE,  16'd3,     10'd1022, 0, STAT_OK,      10'd0, 11'd0},
      '{KIND_FREE,  16'd1,     10'd1023, 0, STAT_OK,      10'd0, 11'd0},
      '{KIND_FREE,  16'd512,   10'd513,  0, STAT_OK,      10'd0, 11'd0},
      '{KIND_FREE,  16'd7,     10'd512,  0, STAT_OK,      10'd0, 11'd0},
      '{KIND_FREE,  16'd512,   10'd0,    0, STAT_OK,      10'd0, 11'd0},
      '{KIND_FREE,  16'hFFFF,  10'h3FF,  0, STAT_OK,      10'd0, 11'd0},
      '{KIND_ALLOC, 16'd1024,  10'd0,    0, STAT_OK,      10'd0, 11'd0},
      '{KIND_ALLOC, 16'h8000,  10'd0,    0, STAT_OK,      10'd0, 11'd0}
    };
    foreach (dir_rows[i]) send_request(dir_rows[i], 1);

    // random traffic over several page counts, idle-free at the end
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) write_page_count($urandom_range(1, NUM_PAGES));
      else write_page_count(phase_cfg[p]);
      repeat (42) send_request(random_row(), p < NUM_PHASES - 1);
    end
    drain_results();
    repeat (64) @(posedge clk);

    if (fail_count == 0 && pending_grants.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/bpa_pkg.sv
sv/bpa_cell.sv
sv/bpa_ctrl.sv
sv/buddy_page_allocator.sv
tb/sv/tb_top.sv
